>>> hw/rtl/scbp_pkg.sv
// ----------------------------------------------------------------------------
// scbp_pkg
// Shared types and constants of the size-class block pool.
// ----------------------------------------------------------------------------
`default_nettype none

package scbp_pkg;

  localparam int NUM_CLASSES_DEF      = 4;
  localparam int BLOCKS_PER_CLASS_DEF = 32768;

  localparam int SIZE_REGS = 4;
  localparam int CLS_W     = 3;
  localparam int LEN_W     = 32;
  localparam int BLK_W     = 15;
  localparam int CNT_W     = 16;
  localparam int REG_IDX_W = 3;

  localparam logic [LEN_W-1:0] SIZE0_RST      = 32'(16 * 1024);
  localparam logic [LEN_W-1:0] SIZE1_RST      = 32'(64 * 1024);
  localparam logic [LEN_W-1:0] SIZE2_RST      = 32'(256 * 1024);
  localparam logic [LEN_W-1:0] SIZE3_RST      = 32'(1024 * 1024);
  localparam logic [CNT_W-1:0] MAX_BLOCKS_RST = 16'(1024 * 24);
  localparam logic [CNT_W-1:0] QUANTUM_RST    = 16'(128);
  localparam logic [CNT_W-1:0] INITIAL_RST    = 16'(0);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SIZE0          = 3'd0,
    REG_SIZE1          = 3'd1,
    REG_SIZE2          = 3'd2,
    REG_SIZE3          = 3'd3,
    REG_MAX_BLOCKS     = 3'd4,
    REG_GROW_QUANTUM   = 3'd5,
    REG_INITIAL_BLOCKS = 3'd6,
    REG_SMALLEST_ONLY  = 3'd7
  } scbp_reg_e;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } scbp_mode_e;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } scbp_status_e;

  typedef struct packed {
    logic [SIZE_REGS-1:0][LEN_W-1:0] class_size;
    logic [CNT_W-1:0]                max_blocks;
    logic [CNT_W-1:0]                grow_quantum;
    logic [CNT_W-1:0]                initial_blocks;
    logic                            smallest_only;
  } scbp_cfg_t;

  typedef struct packed {
    logic              is_free;
    logic              found;
    logic [CLS_W-1:0]  cls;
    logic [LEN_W-1:0]  length;
    logic [BLK_W-1:0]  free_block;
  } scbp_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/scbp_cfg_regs.sv
// ----------------------------------------------------------------------------
// scbp_cfg_regs
// Configuration register file of the block pool, written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module scbp_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [scbp_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [scbp_pkg::LEN_W-1:0]         cfg_wdata_i,
  output scbp_pkg::scbp_cfg_t                     cfg_o
);

  scbp_pkg::scbp_cfg_t cfg_q;
  scbp_pkg::scbp_reg_e reg_idx;

  assign reg_idx = scbp_pkg::scbp_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_size[0]  <= scbp_pkg::SIZE0_RST;
      cfg_q.class_size[1]  <= scbp_pkg::SIZE1_RST;
      cfg_q.class_size[2]  <= scbp_pkg::SIZE2_RST;
      cfg_q.class_size[3]  <= scbp_pkg::SIZE3_RST;
      cfg_q.max_blocks     <= scbp_pkg::MAX_BLOCKS_RST;
      cfg_q.grow_quantum   <= scbp_pkg::QUANTUM_RST;
      cfg_q.initial_blocks <= scbp_pkg::INITIAL_RST;
      cfg_q.smallest_only  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx) inside
        scbp_pkg::REG_SIZE0, scbp_pkg::REG_SIZE1,
        scbp_pkg::REG_SIZE2, scbp_pkg::REG_SIZE3: begin
          cfg_q.class_size[cfg_index_i[1:0]] <= cfg_wdata_i;
        end
        scbp_pkg::REG_MAX_BLOCKS: begin
          cfg_q.max_blocks <= cfg_wdata_i[scbp_pkg::CNT_W-1:0];
        end
        scbp_pkg::REG_GROW_QUANTUM: begin
          cfg_q.grow_quantum <= cfg_wdata_i[scbp_pkg::CNT_W-1:0];
        end
        scbp_pkg::REG_INITIAL_BLOCKS: begin
          cfg_q.initial_blocks <= cfg_wdata_i[scbp_pkg::CNT_W-1:0];
        end
        scbp_pkg::REG_SMALLEST_ONLY: begin
          cfg_q.smallest_only <= cfg_wdata_i[0];
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> hw/rtl/scbp_front.sv
// ----------------------------------------------------------------------------
// scbp_front
// Accepts request beats, picks the first fitting class or checks a free.
// ----------------------------------------------------------------------------
`default_nettype none

module scbp_front #(
  parameter int NUM_CLASSES      = scbp_pkg::NUM_CLASSES_DEF,
  parameter int BLOCKS_PER_CLASS = scbp_pkg::BLOCKS_PER_CLASS_DEF
) (
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic                         mode_i,
  input  wire logic [scbp_pkg::LEN_W-1:0]   length_i,
  input  wire logic [1:0]                   free_class_i,
  input  wire logic [scbp_pkg::BLK_W-1:0]   free_block_i,
  input  scbp_pkg::scbp_cfg_t               cfg_i,
  input  wire logic                         q_full_i,
  output      logic                         q_push_o,
  output scbp_pkg::scbp_cmd_t               cmd_o
);

  logic [NUM_CLASSES-1:0]           fits;
  logic                             any_fit;
  logic [scbp_pkg::CLS_W-1:0]       first_fit;
  logic                             free_ok;

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (c < scbp_pkg::SIZE_REGS) begin
        fits[c] = (length_i <= cfg_i.class_size[c % scbp_pkg::SIZE_REGS]);
      end else begin
        fits[c] = (length_i == '0);
      end
    end
  end

  always_comb begin
    any_fit   = 1'b0;
    first_fit = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (fits[c]) begin
        any_fit   = 1'b1;
        first_fit = scbp_pkg::CLS_W'(c);
      end
    end
  end

  assign free_ok = (32'(free_class_i) < 32'(NUM_CLASSES)) &&
                   (32'(free_block_i) < 32'(BLOCKS_PER_CLASS));

  always_comb begin
    cmd_o.is_free    = (mode_i == scbp_pkg::MODE_FREE);
    cmd_o.length     = length_i;
    cmd_o.free_block = free_block_i;
    if (mode_i == scbp_pkg::MODE_FREE) begin
      cmd_o.found = free_ok;
      cmd_o.cls   = scbp_pkg::CLS_W'(free_class_i);
    end else begin
      cmd_o.found = any_fit;
      cmd_o.cls   = first_fit;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

>>> hw/rtl/scbp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// scbp_cmd_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module scbp_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  scbp_pkg::scbp_cmd_t push_data_i,
  output      logic          full_o,
  input  wire logic          pop_i,
  output      logic          valid_o,
  output scbp_pkg::scbp_cmd_t pop_data_o
);

  scbp_pkg::scbp_cmd_t entry_q [2];
  logic                wptr_q;
  logic                rptr_q;
  logic [1:0]          cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        entry_q[wptr_q] <= push_data_i;
        wptr_q          <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = entry_q[rptr_q];

endmodule

`default_nettype wire

>>> hw/rtl/scbp_back.sv
// ----------------------------------------------------------------------------
// scbp_back
// Carries out frees and allocations: free stacks, fresh counters, growth.
// ----------------------------------------------------------------------------
`default_nettype none

module scbp_back #(
  parameter int NUM_CLASSES      = scbp_pkg::NUM_CLASSES_DEF,
  parameter int BLOCKS_PER_CLASS = scbp_pkg::BLOCKS_PER_CLASS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  scbp_pkg::scbp_cfg_t               cfg_i,
  input  wire logic                         cmd_valid_i,
  input  scbp_pkg::scbp_cmd_t               cmd_i,
  output      logic                         cmd_pop_o,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic                         status_o,
  output      logic [1:0]                   class_index_o,
  output      logic [scbp_pkg::BLK_W-1:0]   block_index_o,
  output      logic [scbp_pkg::LEN_W-1:0]   granted_length_o
);

  localparam int CIW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int DW        = $clog2(BLOCKS_PER_CLASS + 1);
  localparam int GW        = (DW > scbp_pkg::CNT_W) ? DW : scbp_pkg::CNT_W;
  localparam int MEM_DEPTH = NUM_CLASSES * BLOCKS_PER_CLASS;
  localparam int AW        = $clog2(MEM_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRY,
    S_GROW,
    S_READ,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic [CIW-1:0]               cls_q;
  logic [scbp_pkg::LEN_W-1:0]   len_q;
  logic [scbp_pkg::BLK_W-1:0]   blk_q;
  logic                         ok_q;
  logic [DW-1:0]                depth_q [NUM_CLASSES];
  logic [DW-1:0]                grown_q [NUM_CLASSES];
  logic [DW-1:0]                fresh_q [NUM_CLASSES];

  logic                         out_valid_q;
  logic                         status_q;
  logic [1:0]                   class_index_q;
  logic [scbp_pkg::BLK_W-1:0]   block_index_q;
  logic [scbp_pkg::LEN_W-1:0]   granted_length_q;

  logic [scbp_pkg::BLK_W-1:0]   mem [MEM_DEPTH];
  logic [scbp_pkg::BLK_W-1:0]   rd_data_q;

  logic [CIW-1:0]               cmd_cls;
  logic [CIW-1:0]               cur_cls;
  logic [DW-1:0]                cur_depth;
  logic [DW-1:0]                cur_grown;
  logic [DW-1:0]                cur_fresh;
  logic [DW-1:0]                slot_idx;
  logic [AW-1:0]                mem_addr;
  logic                         mem_we;
  logic                         mem_re;
  logic [GW-1:0]                limit;
  logic [GW-1:0]                grown_ext;
  logic [GW-1:0]                quantum_ext;
  logic [GW-1:0]                initial_ext;
  logic [GW-1:0]                room;
  logic [GW-1:0]                grow_n;
  logic                         last_try;

  assign cmd_cls   = cmd_i.cls[CIW-1:0];
  assign cur_cls   = (state_q == S_IDLE) ? cmd_cls : cls_q;
  assign cur_depth = depth_q[cur_cls];
  assign cur_grown = grown_q[cur_cls];
  assign cur_fresh = fresh_q[cur_cls];

  assign slot_idx = (state_q == S_IDLE) ? cur_depth : cur_depth - DW'(1);
  assign mem_addr = AW'(cur_cls) * AW'(BLOCKS_PER_CLASS) + AW'(slot_idx);
  assign mem_we   = (state_q == S_IDLE) && cmd_valid_i && cmd_i.is_free &&
                    cmd_i.found && (cur_depth < DW'(BLOCKS_PER_CLASS));
  assign mem_re   = (state_q == S_TRY) && (cur_depth != '0);

  assign grown_ext   = GW'(cur_grown);
  assign quantum_ext = GW'(cfg_i.grow_quantum);
  assign initial_ext = GW'(cfg_i.initial_blocks);
  assign limit       = (GW'(cfg_i.max_blocks) < GW'(BLOCKS_PER_CLASS)) ?
                       GW'(cfg_i.max_blocks) : GW'(BLOCKS_PER_CLASS);
  assign room        = (grown_ext < limit) ? (limit - grown_ext) : '0;

  always_comb begin
    if (grown_ext == '0) begin
      grow_n = (initial_ext < limit) ? initial_ext : limit;
      if (grow_n == '0) begin
        grow_n = (quantum_ext < limit) ? quantum_ext : limit;
      end
    end else begin
      grow_n = (quantum_ext < room) ? quantum_ext : room;
    end
  end

  assign last_try  = (cls_q == CIW'(NUM_CLASSES - 1)) || cfg_i.smallest_only;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= cmd_i.free_block;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      cls_q            <= '0;
      len_q            <= '0;
      blk_q            <= '0;
      ok_q             <= 1'b0;
      out_valid_q      <= 1'b0;
      status_q         <= scbp_pkg::STATUS_OK;
      class_index_q    <= '0;
      block_index_q    <= '0;
      granted_length_q <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        depth_q[c] <= '0;
        grown_q[c] <= '0;
        fresh_q[c] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.is_free) begin
              if (mem_we) begin
                depth_q[cur_cls] <= cur_depth + DW'(1);
              end
            end else if (!cmd_i.found) begin
              ok_q    <= 1'b0;
              state_q <= S_DONE;
            end else begin
              cls_q   <= cmd_cls;
              len_q   <= cmd_i.length;
              state_q <= S_TRY;
            end
          end
        end
        S_TRY: begin
          if (cur_depth != '0) begin
            depth_q[cur_cls] <= cur_depth - DW'(1);
            state_q          <= S_READ;
          end else if (cur_fresh < cur_grown) begin
            blk_q            <= scbp_pkg::BLK_W'(cur_fresh);
            fresh_q[cur_cls] <= cur_fresh + DW'(1);
            ok_q             <= 1'b1;
            state_q          <= S_DONE;
          end else begin
            state_q <= S_GROW;
          end
        end
        S_GROW: begin
          if (grow_n != '0) begin
            grown_q[cur_cls] <= cur_grown + DW'(grow_n);
            blk_q            <= scbp_pkg::BLK_W'(cur_fresh);
            fresh_q[cur_cls] <= cur_fresh + DW'(1);
            ok_q             <= 1'b1;
            state_q          <= S_DONE;
          end else if (last_try) begin
            ok_q    <= 1'b0;
            state_q <= S_DONE;
          end else begin
            cls_q   <= cls_q + CIW'(1);
            state_q <= S_TRY;
          end
        end
        S_READ: begin
          blk_q   <= rd_data_q;
          ok_q    <= 1'b1;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            if (ok_q) begin
              status_q         <= scbp_pkg::STATUS_OK;
              class_index_q    <= 2'(cls_q);
              block_index_q    <= blk_q;
              granted_length_q <= len_q;
            end else begin
              status_q         <= scbp_pkg::STATUS_ERR;
              class_index_q    <= '0;
              block_index_q    <= '0;
              granted_length_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign class_index_o    = class_index_q;
  assign block_index_o    = block_index_q;
  assign granted_length_o = granted_length_q;

endmodule

`default_nettype wire

>>> hw/rtl/size_class_block_pool.sv
// ----------------------------------------------------------------------------
// size_class_block_pool
// Block pool with ascending size classes, per-class free stacks and growth.
// ----------------------------------------------------------------------------
// The front takes one request beat per cycle into a two-entry queue while
// the back works through earlier ones, so a result waiting on out_ready_i
// does not stop new beats until the queue is full. In the back a free is
// pushed onto its class's free stack from the idle state, and a length that
// fits no class goes straight to the done state and is refused. An
// allocation pops its class's free stack if it holds entries, through a
// registered stack-memory read, else takes a never-used block if one is
// ready, else grows its class; when growth fails it tries the next class,
// unless smallest_only is set, and is refused when no class is left. The back
// uses a single stack-memory port for pushes and pops. The free-stack memory
// is not cleared after reset: only entries already pushed are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_block_pool #(
  parameter int NUM_CLASSES      = scbp_pkg::NUM_CLASSES_DEF,
  parameter int BLOCKS_PER_CLASS = scbp_pkg::BLOCKS_PER_CLASS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [scbp_pkg::REG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [scbp_pkg::LEN_W-1:0]       cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output      logic                             in_ready_o,
  input  wire logic                             mode_i,
  input  wire logic [scbp_pkg::LEN_W-1:0]       length_i,
  input  wire logic [1:0]                       free_class_i,
  input  wire logic [scbp_pkg::BLK_W-1:0]       free_block_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic                             status_o,
  output      logic [1:0]                       class_index_o,
  output      logic [scbp_pkg::BLK_W-1:0]       block_index_o,
  output      logic [scbp_pkg::LEN_W-1:0]       granted_length_o
);

  scbp_pkg::scbp_cfg_t cfg;
  scbp_pkg::scbp_cmd_t push_cmd;
  scbp_pkg::scbp_cmd_t pop_cmd;
  logic                q_full;
  logic                q_push;
  logic                q_valid;
  logic                q_pop;

  scbp_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scbp_front #(
    .NUM_CLASSES      (NUM_CLASSES),
    .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .length_i     (length_i),
    .free_class_i (free_class_i),
    .free_block_i (free_block_i),
    .cfg_i        (cfg),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .cmd_o        (push_cmd)
  );

  scbp_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_cmd)
  );

  scbp_back #(
    .NUM_CLASSES      (NUM_CLASSES),
    .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_valid_i      (q_valid),
    .cmd_i            (pop_cmd),
    .cmd_pop_o        (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .class_index_o    (class_index_o),
    .block_index_o    (block_index_o),
    .granted_length_o (granted_length_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/scbp_checker.sv
// ----------------------------------------------------------------------------
// scbp_checker
// Port-level checks of the block pool, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scbp_checker #(
  parameter int NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic                           status_o,
  input wire logic [1:0]                     class_index_o,
  input wire logic [scbp_pkg::BLK_W-1:0]     block_index_o,
  input wire logic [scbp_pkg::LEN_W-1:0]     granted_length_o
);

  // drop results while in reset
  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result beat shown during reset");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == scbp_pkg::STATUS_ERR) |->
      (class_index_o == 2'd0 && block_index_o == '0 && granted_length_o == '0))
    else $error("error beat carries non-zero payload");

  a_grant_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == scbp_pkg::STATUS_OK) |->
      (32'(class_index_o) < 32'(NUM_CLASSES)))
    else $error("granted class out of range");

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(class_index_o) &&
       $stable(block_index_o) && $stable(granted_length_o)))
    else $error("stalled result beat changed");

endmodule

bind size_class_block_pool scbp_checker #(
  .NUM_CLASSES (NUM_CLASSES)
) u_scbp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .status_o         (status_o),
  .class_index_o    (class_index_o),
  .block_index_o    (block_index_o),
  .granted_length_o (granted_length_o)
);

`default_nettype wire
